@@ src/wsd_pkg.sv @@
package wsd_pkg;

   // Frame kinds reported with every result.
   localparam logic [3:0] KIND_CONT       = 4'd0;
   localparam logic [3:0] KIND_CONT_FINAL = 4'd1;
   localparam logic [3:0] KIND_TEXT       = 4'd2;
   localparam logic [3:0] KIND_TEXT_START = 4'd3;
   localparam logic [3:0] KIND_BIN        = 4'd4;
   localparam logic [3:0] KIND_BIN_START  = 4'd5;
   localparam logic [3:0] KIND_CLOSE      = 4'd6;
   localparam logic [3:0] KIND_PING       = 4'd7;
   localparam logic [3:0] KIND_PONG       = 4'd8;
   localparam logic [3:0] KIND_ERROR      = 4'd9;

   // Opcodes from the first header byte.
   localparam logic [3:0] OP_CONT  = 4'h0;
   localparam logic [3:0] OP_TEXT  = 4'h1;
   localparam logic [3:0] OP_BIN   = 4'h2;
   localparam logic [3:0] OP_CLOSE = 4'h8;
   localparam logic [3:0] OP_PING  = 4'h9;
   localparam logic [3:0] OP_PONG  = 4'hA;

   // Seven-bit length field codes.
   localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
   localparam logic [6:0] LEN_EXT16     = 7'd126;

   typedef struct packed {
      logic       valid;
      logic [3:0] frame_kind;
      logic [7:0] payload_byte;
      logic       has_byte;
      logic       last_of_frame;
   } wsd_result_type;

   function automatic logic [3:0] kind_of(input logic [7:0] hdr0);
      logic       fin;
      logic [3:0] kind;
      fin = hdr0[7];
      case (hdr0[3:0])
         OP_CONT:  kind = fin ? KIND_CONT_FINAL : KIND_CONT;
         OP_TEXT:  kind = fin ? KIND_TEXT : KIND_TEXT_START;
         OP_BIN:   kind = fin ? KIND_BIN : KIND_BIN_START;
         OP_CLOSE: kind = fin ? KIND_CLOSE : KIND_ERROR;
         OP_PING:  kind = fin ? KIND_PING : KIND_ERROR;
         OP_PONG:  kind = fin ? KIND_PONG : KIND_ERROR;
         default:  kind = KIND_ERROR;
      endcase
      return kind;
   endfunction

endpackage

@@ src/wsd_parser.sv @@
module wsd_parser (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      step,
   input  logic [7:0]                stream_byte,
   output wsd_pkg::wsd_result_type   result
);

   typedef enum logic [2:0] {
      PH_HDR0 = 3'd0,
      PH_HDR1 = 3'd1,
      PH_EXT  = 3'd2,
      PH_MASK = 3'd3,
      PH_DATA = 3'd4
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [3:0]  ext_left_ff, ext_left_in;
   logic [63:0] payload_left_ff, payload_left_in;
   logic [31:0] mask_key_ff, mask_key_in;
   logic [1:0]  mask_phase_ff, mask_phase_in;
   logic [2:0]  mask_left_ff, mask_left_in;
   logic        is_masked_ff, is_masked_in;
   logic [3:0]  kind_ff, kind_in;

   logic [6:0]  len_field;
   logic [63:0] payload_dec;
   logic [7:0]  mask_byte;
   logic        hdr_done;
   logic [63:0] done_len;

   assign len_field   = stream_byte[6:0];
   assign payload_dec = payload_left_ff - 64'd1;

   always_comb begin
      case (mask_phase_ff)
         2'd0:    mask_byte = mask_key_ff[31:24];
         2'd1:    mask_byte = mask_key_ff[23:16];
         2'd2:    mask_byte = mask_key_ff[15:8];
         default: mask_byte = mask_key_ff[7:0];
      endcase
   end

   always_comb begin
      phase_in        = phase_ff;
      ext_left_in     = ext_left_ff;
      payload_left_in = payload_left_ff;
      mask_key_in     = mask_key_ff;
      mask_phase_in   = mask_phase_ff;
      mask_left_in    = mask_left_ff;
      is_masked_in    = is_masked_ff;
      kind_in         = kind_ff;
      hdr_done        = 1'b0;
      done_len        = payload_left_ff;
      result          = '0;
      result.frame_kind = kind_ff;

      unique case (phase_ff)
         PH_HDR1: begin
            is_masked_in  = stream_byte[7];
            mask_left_in  = stream_byte[7] ? 3'd4 : 3'd0;
            mask_key_in   = '0;
            mask_phase_in = '0;
            if (len_field <= wsd_pkg::LEN_SHORT_MAX) begin
               payload_left_in = {57'd0, len_field};
               ext_left_in     = 4'd0;
               if (stream_byte[7]) begin
                  phase_in = PH_MASK;
               end else begin
                  hdr_done = 1'b1;
                  done_len = {57'd0, len_field};
               end
            end else begin
               payload_left_in = '0;
               ext_left_in     = (len_field == wsd_pkg::LEN_EXT16) ? 4'd2 : 4'd8;
               phase_in        = PH_EXT;
            end
         end
         PH_EXT: begin
            payload_left_in = {payload_left_ff[55:0], stream_byte};
            ext_left_in     = ext_left_ff - 4'd1;
            if (ext_left_in == 4'd0) begin
               if (mask_left_ff != 3'd0) begin
                  phase_in = PH_MASK;
               end else begin
                  hdr_done = 1'b1;
                  done_len = payload_left_in;
               end
            end
         end
         PH_MASK: begin
            mask_key_in  = {mask_key_ff[23:0], stream_byte};
            mask_left_in = mask_left_ff - 3'd1;
            if (mask_left_in == 3'd0) begin
               hdr_done = 1'b1;
               done_len = payload_left_ff;
            end
         end
         PH_DATA: begin
            mask_phase_in        = mask_phase_ff + 2'd1;
            payload_left_in      = payload_dec;
            result.valid         = 1'b1;
            result.has_byte      = 1'b1;
            result.payload_byte  = stream_byte ^ (is_masked_ff ? mask_byte : 8'd0);
            result.last_of_frame = (payload_dec == 64'd0);
            if (payload_dec == 64'd0) begin
               phase_in = PH_HDR0;
            end
         end
         default: begin
            // First header byte; unused phase codes land here as well.
            kind_in  = wsd_pkg::kind_of(stream_byte);
            phase_in = PH_HDR1;
         end
      endcase

      if (hdr_done) begin
         mask_phase_in = '0;
         if (done_len == 64'd0) begin
            // A zero-length frame closes on its last header byte.
            phase_in             = PH_HDR0;
            result.valid         = 1'b1;
            result.last_of_frame = 1'b1;
         end else begin
            phase_in = PH_DATA;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HDR0;
         ext_left_ff     <= '0;
         payload_left_ff <= '0;
         mask_key_ff     <= '0;
         mask_phase_ff   <= '0;
         mask_left_ff    <= '0;
         is_masked_ff    <= 1'b0;
         kind_ff         <= '0;
      end else if (step) begin
         phase_ff        <= phase_in;
         ext_left_ff     <= ext_left_in;
         payload_left_ff <= payload_left_in;
         mask_key_ff     <= mask_key_in;
         mask_phase_ff   <= mask_phase_in;
         mask_left_ff    <= mask_left_in;
         is_masked_ff    <= is_masked_in;
         kind_ff         <= kind_in;
      end
   end

endmodule

@@ src/websocket_frame_deframer.sv @@
// WebSocket frame deframer. The block takes a received WebSocket stream one byte per
// transaction, parses each frame header (FIN and opcode, mask flag, 7-bit length with the
// 16-bit or 64-bit big-endian extended forms, optional 4-byte mask key) and then returns
// every payload byte once, unmasked with the rotating key and tagged with a frame kind.
// Header bytes return nothing, except the last header byte of a zero-length frame, which
// returns one transaction with has_byte low and last_of_frame high. Control frames without
// FIN and unknown opcodes are tagged as errors but still parsed. The block sustains one
// byte per clock cycle while the result output is not stalled. An accepted byte is held in
// the input register until the parser consumes it; its result is loaded into the result
// register, which offers it on the output. While a result waits on a stalled output, the
// input register still takes one more byte if it is empty; after that the input stalls
// until the waiting result is taken.
module websocket_frame_deframer (
   input  logic       clock,
   input  logic       reset,

   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_stream_byte,

   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [3:0] rsp_frame_kind,
   output logic [7:0] rsp_payload_byte,
   output logic       rsp_has_byte,
   output logic       rsp_last_of_frame
);

   // Input register: holds one accepted byte until the parser consumes it.
   logic       in_valid_ff;
   logic [7:0] in_byte_ff;

   // Result register.
   logic       out_valid_ff;
   logic [3:0] out_kind_ff;
   logic [7:0] out_byte_ff;
   logic       out_has_ff;
   logic       out_last_ff;

   logic                    advance;
   wsd_pkg::wsd_result_type result;

   // The held byte is consumed when the result register is free or is being drained
   // in this cycle. Header bytes without a result follow the same rule so that the
   // order of results is never in doubt.
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   wsd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .stream_byte (in_byte_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_valid && !req_stall) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_byte_ff <= req_stream_byte;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance && result.valid) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   // Payload of the result register; it only loads when the register is free or
   // draining, so a stalled transaction stays put.
   always_ff @(posedge clock) begin
      if (advance && result.valid) begin
         out_kind_ff <= result.frame_kind;
         out_byte_ff <= result.payload_byte;
         out_has_ff  <= result.has_byte;
         out_last_ff <= result.last_of_frame;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_frame_kind    = out_kind_ff;
   assign rsp_payload_byte  = out_byte_ff;
   assign rsp_has_byte      = out_has_ff;
   assign rsp_last_of_frame = out_last_ff;

endmodule

@@ src/wsd_checker.sv @@
module wsd_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_stall,
   input logic       rsp_valid,
   input logic       rsp_stall,
   input logic [3:0] rsp_frame_kind,
   input logic [7:0] rsp_payload_byte,
   input logic       rsp_has_byte,
   input logic       rsp_last_of_frame
);

   // A stalled result transaction is still offered in the next cycle.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid)
      else $error("result transaction dropped while stalled");

   // A result without a payload byte only ever closes a zero-length frame.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_has_byte |-> rsp_last_of_frame && (rsp_payload_byte == 8'd0))
      else $error("byteless result that does not close a frame");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_frame_kind <= wsd_pkg::KIND_ERROR)
      else $error("frame kind out of range");

   // Nothing is in flight right after reset.
   assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("block not empty after reset");

endmodule

bind websocket_frame_deframer wsd_checker u_wsd_checker (
   .clock             (clock),
   .reset             (reset),
   .req_stall         (req_stall),
   .rsp_valid         (rsp_valid),
   .rsp_stall         (rsp_stall),
   .rsp_frame_kind    (rsp_frame_kind),
   .rsp_payload_byte  (rsp_payload_byte),
   .rsp_has_byte      (rsp_has_byte),
   .rsp_last_of_frame (rsp_last_of_frame)
);
